// File: design/pmc_pkg.sv
package pmc_pkg;

    // Event ring depth; one slot stays free, so it holds FIFO_DEPTH-1 events.
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W         = 1;
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Reset values
    localparam logic [COORD_W-1:0] RST_X_TOP = 12'd1919;  // width 1920
    localparam logic [COORD_W-1:0] RST_Y_TOP = 12'd1079;  // height 1080
    localparam logic [COORD_W-1:0] RST_POS_X = 12'd400;
    localparam logic [COORD_W-1:0] RST_POS_Y = 12'd300;

    typedef struct packed {
        logic               middle;
        logic               right;
        logic               left;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_event;

    typedef struct packed {
        logic         push;
        t_event       ev;
    } t_push;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

// File: design/ps2_mouse_packet_cursor_fifo.sv
// Channel   Dir  Handshake                  Payload
// in        in   i_in_valid / o_in_ready    i_opcode, i_data_byte
// out       out  o_out_valid / i_out_ready  o_event_valid, o_ev_*, o_cur_*
// cfg       in   i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One item per cycle unless a stalled output blocks input. A byte finishes at
// its accept edge (add, clamp and event RAM write all at that edge); a pop
// reads the event RAM at its accept edge and its result shows the next cycle.
// Reset (synchronous, active low) clears pointers and packet state, resets the
// cursor; the event RAM is not cleared, only written entries are ever read.
// A stalled output holds its result and blocks input unless it drains now.
module ps2_mouse_packet_cursor_fifo
    import pmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [7:0]           i_data_byte,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_event_valid,
    output logic [COORD_W-1:0]   o_ev_x,
    output logic [COORD_W-1:0]   o_ev_y,
    output logic                 o_ev_left,
    output logic                 o_ev_right,
    output logic                 o_ev_middle,
    output logic [COORD_W-1:0]   o_cur_x,
    output logic [COORD_W-1:0]   o_cur_y,
    output logic [7:0]           o_cur_buttons
);

    t_cfg_wr            cfg;
    t_push              push;
    t_event             rd_ev;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [7:0]         last_btn;

    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_next;
    logic               fifo_full;
    logic               fifo_empty;

    logic               in_acc;
    logic               byte_acc;
    logic               pop_acc;
    logic               do_write;
    logic               do_read;

    // output slot
    logic               r_out_valid;
    logic               r_ev_valid;
    logic [COORD_W-1:0] r_cur_x;
    logic [COORD_W-1:0] r_cur_y;
    logic [7:0]         r_cur_btn;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign byte_acc   = in_acc && (i_opcode == OP_BYTE);
    assign pop_acc    = in_acc && (i_opcode == OP_POP);

    assign wp_next    = ptr_inc(r_wp);
    assign rp_next    = ptr_inc(r_rp);
    assign fifo_full  = (wp_next == r_rp);
    assign fifo_empty = (r_wp == r_rp);

    // a push and a pop never share a cycle, so no same-entry overlap
    assign do_write = push.push && !fifo_full;
    assign do_read  = pop_acc && !fifo_empty;

    pmc_cursor u_cursor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_byte_we      (byte_acc),
        .i_byte         (i_data_byte),
        .o_push         (push),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_last_buttons (last_btn)
    );

    pmc_event_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH ($bits(t_event))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wp),
        .i_wdata (push.ev),
        .i_re    (do_read),
        .i_raddr (r_rp),
        .o_rdata (rd_ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
            r_ev_valid  <= 1'b0;
        end else begin
            if (do_write) begin
                r_wp <= wp_next;
            end
            if (do_read) begin
                r_rp <= rp_next;
            end
            if (pop_acc) begin
                r_out_valid <= 1'b1;
                r_ev_valid  <= !fifo_empty;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cursor snapshot taken at the pop's accept edge
    always_ff @(posedge i_clk) begin
        if (pop_acc) begin
            r_cur_x   <= pos_x;
            r_cur_y   <= pos_y;
            r_cur_btn <= last_btn;
        end
    end

    // empty pop shows zeros in the event fields
    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_ev_valid;
    assign o_ev_x        = r_ev_valid ? rd_ev.x : '0;
    assign o_ev_y        = r_ev_valid ? rd_ev.y : '0;
    assign o_ev_left     = r_ev_valid && rd_ev.left;
    assign o_ev_right    = r_ev_valid && rd_ev.right;
    assign o_ev_middle   = r_ev_valid && rd_ev.middle;
    assign o_cur_x       = r_cur_x;
    assign o_cur_y       = r_cur_y;
    assign o_cur_buttons = r_cur_btn;

`ifndef SYNTH
    a_pop_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_acc && !fifo_empty) |=> (o_out_valid && o_event_valid))
        else $error("pop of a non-empty ring did not return an event");

    a_pop_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_acc && fifo_empty) |=> (o_out_valid && !o_event_valid))
        else $error("pop of an empty ring returned an event");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.push && fifo_full) |=> $stable(r_wp))
        else $error("write pointer moved on a dropped event");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output slot is stalled");
`endif

endmodule

// File: design/pmc_event_ram.sv
module pmc_event_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 27
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: design/pmc_cursor.sv
module pmc_cursor
    import pmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg_wr            i_cfg,
    input  logic               i_byte_we,
    input  logic [7:0]         i_byte,
    output t_push              o_push,
    output logic [COORD_W-1:0] o_pos_x,
    output logic [COORD_W-1:0] o_pos_y,
    output logic [7:0]         o_last_buttons
);

    typedef enum logic [1:0] {
        BI_BUTTONS,
        BI_DX,
        BI_DY
    } t_byte_idx;

    t_byte_idx          r_idx, n_idx;
    logic [7:0]         r_btn_byte;
    logic [7:0]         r_dx_byte;
    logic [COORD_W-1:0] r_pos_x, n_pos_x;
    logic [COORD_W-1:0] r_pos_y, n_pos_y;
    logic [7:0]         r_last_btn;
    logic [COORD_W-1:0] r_x_top;
    logic [COORD_W-1:0] r_y_top;

    logic signed [7:0]  dx_s;
    logic signed [7:0]  dy_s;
    logic signed [13:0] sum_x;
    logic signed [13:0] sum_y;
    logic               pkt_done;

    // largest coordinate for a size register: 0 acts as 1, above 4096 as 4096
    function automatic logic [COORD_W-1:0] size_top(input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] dec;
        dec = s - 1'b1;
        if (s == '0) begin
            return '0;
        end else if (s[CFG_W-1]) begin
            return '1;
        end else begin
            return dec[COORD_W-1:0];
        end
    endfunction

    function automatic logic [COORD_W-1:0] clamp(input logic signed [13:0] v,
                                                  input logic [COORD_W-1:0] top);
        if (v < 0) begin
            return '0;
        end else if (v > signed'({2'b00, top})) begin
            return top;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    assign dx_s  = r_dx_byte;
    assign dy_s  = i_byte;
    assign sum_x = signed'({2'b00, r_pos_x}) + 14'(dx_s);
    assign sum_y = signed'({2'b00, r_pos_y}) - 14'(dy_s);

    always_comb begin
        n_idx    = r_idx;
        pkt_done = 1'b0;
        unique case (r_idx)
            BI_BUTTONS: n_idx = BI_DX;
            BI_DX:      n_idx = BI_DY;
            BI_DY: begin
                n_idx    = BI_BUTTONS;
                pkt_done = i_byte_we;
            end
            default:    n_idx = BI_BUTTONS;
        endcase
        n_pos_x = clamp(sum_x, r_x_top);
        n_pos_y = clamp(sum_y, r_y_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= BI_BUTTONS;
            r_btn_byte <= '0;
            r_dx_byte  <= '0;
            r_pos_x    <= RST_POS_X;
            r_pos_y    <= RST_POS_Y;
            r_last_btn <= '0;
            r_x_top    <= RST_X_TOP;
            r_y_top    <= RST_Y_TOP;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_SCREEN_WIDTH:  r_x_top <= size_top(i_cfg.data);
                    CFG_SCREEN_HEIGHT: r_y_top <= size_top(i_cfg.data);
                    default:           r_x_top <= r_x_top;
                endcase
            end
            if (i_byte_we) begin
                r_idx <= n_idx;
                if (r_idx == BI_BUTTONS) begin
                    r_btn_byte <= i_byte;
                end
                if (r_idx == BI_DX) begin
                    r_dx_byte <= i_byte;
                end
                if (pkt_done) begin
                    r_pos_x    <= n_pos_x;
                    r_pos_y    <= n_pos_y;
                    r_last_btn <= r_btn_byte;
                end
            end
        end
    end

    // event carries the freshly clamped position
    assign o_push.push      = pkt_done;
    assign o_push.ev.x      = n_pos_x;
    assign o_push.ev.y      = n_pos_y;
    assign o_push.ev.left   = r_btn_byte[0];
    assign o_push.ev.right  = r_btn_byte[1];
    assign o_push.ev.middle = r_btn_byte[2];

    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_last_buttons = r_last_btn;

endmodule

// File: test/cursor_event_checker.sv
`timescale 1ns / 1ps

// Watches the mouse byte / pop channels, tracks the cursor and the event ring,
// and compares every pop result with its prediction.
module cursor_event_checker
    import pmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_opcode,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_event_valid,
    input  logic [COORD_W-1:0]   i_ev_x,
    input  logic [COORD_W-1:0]   i_ev_y,
    input  logic                 i_ev_left,
    input  logic                 i_ev_right,
    input  logic                 i_ev_middle,
    input  logic [COORD_W-1:0]   i_cur_x,
    input  logic [COORD_W-1:0]   i_cur_y,
    input  logic [7:0]           i_cur_buttons,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_events,
    output int                   o_drops
);

    typedef struct packed {
        logic               ev_valid;
        t_event             ev;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [7:0]         btns;
    } t_pop_view;

    // predicted block state
    int                 x_top;
    int                 y_top;
    int                 pkt_phase;
    logic [7:0]         btn_hold;
    logic [7:0]         dx_hold;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [7:0]         last_btn;
    t_event             ring [FIFO_DEPTH];
    int                 wr_idx;
    int                 rd_idx;

    t_pop_view pop_q [$];

    int n_err     = 0;
    int n_results = 0;
    int n_events  = 0;
    int n_drops   = 0;

    // 0 behaves as 1, anything above 4096 as 4096
    function automatic int size_top(input logic [CFG_W-1:0] s);
        if (s == 0) return 0;
        if (s > 4096) return 4095;
        return int'(s) - 1;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_axis(input int v, input int top);
        int c;
        c = v;
        if (c < 0) c = 0;
        if (c > top) c = top;
        return COORD_W'(c);
    endfunction

    task automatic track_byte(input logic [7:0] b);
        t_event ev;
        int     nxt;
        case (pkt_phase)
            0: begin
                btn_hold  = b;
                pkt_phase = 1;
            end
            1: begin
                dx_hold   = b;
                pkt_phase = 2;
            end
            default: begin
                pkt_phase = 0;
                cur_x     = clamp_axis(int'(cur_x) + int'($signed(dx_hold)), x_top);
                cur_y     = clamp_axis(int'(cur_y) - int'($signed(b)), y_top);
                last_btn  = btn_hold;
                nxt       = (wr_idx + 1) % FIFO_DEPTH;
                if (nxt != rd_idx) begin
                    ev.x      = cur_x;
                    ev.y      = cur_y;
                    ev.left   = btn_hold[0];
                    ev.right  = btn_hold[1];
                    ev.middle = btn_hold[2];
                    ring[wr_idx] = ev;
                    wr_idx    = nxt;
                end else begin
                    n_drops++;
                end
            end
        endcase
    endtask

    task automatic predict_pop();
        t_pop_view r;
        r = '0;
        if (wr_idx != rd_idx) begin
            r.ev_valid = 1'b1;
            r.ev       = ring[rd_idx];
            rd_idx     = (rd_idx + 1) % FIFO_DEPTH;
        end
        r.cx   = cur_x;
        r.cy   = cur_y;
        r.btns = last_btn;
        pop_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_err++;
            if (n_err <= 10)
                $display("checker: result %0d field %s: expected %0d, got %0d",
                         n_results, name, want, got);
        end
    endtask

    task automatic check_result();
        t_pop_view want;
        if (pop_q.size() == 0) begin
            n_err++;
            if (n_err <= 10)
                $display("checker: result with no pop pending (x %0d y %0d)", i_cur_x, i_cur_y);
        end else begin
            want = pop_q.pop_front();
            if (want.ev_valid) n_events++;
            check_field("event_valid", int'(want.ev_valid), int'(i_event_valid));
            check_field("ev_x", int'(want.ev.x), int'(i_ev_x));
            check_field("ev_y", int'(want.ev.y), int'(i_ev_y));
            check_field("ev_left", int'(want.ev.left), int'(i_ev_left));
            check_field("ev_right", int'(want.ev.right), int'(i_ev_right));
            check_field("ev_middle", int'(want.ev.middle), int'(i_ev_middle));
            check_field("cur_x", int'(want.cx), int'(i_cur_x));
            check_field("cur_y", int'(want.cy), int'(i_cur_y));
            check_field("cur_buttons", int'(want.btns), int'(i_cur_buttons));
        end
        n_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_top     = int'(RST_X_TOP);
            y_top     = int'(RST_Y_TOP);
            pkt_phase = 0;
            btn_hold  = '0;
            dx_hold   = '0;
            cur_x     = RST_POS_X;
            cur_y     = RST_POS_Y;
            last_btn  = '0;
            wr_idx    = 0;
            rd_idx    = 0;
            pop_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SCREEN_WIDTH) x_top = size_top(i_cfg_data);
                else y_top = size_top(i_cfg_data);
            end
            // a pop accepted now shows up next cycle at the earliest
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_POP) predict_pop();
                else track_byte(i_data_byte);
            end
        end
        o_errors  <= n_err;
        o_pending <= pop_q.size();
        o_results <= n_results;
        o_events  <= n_events;
        o_drops   <= n_drops;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import pmc_pkg::*;

    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int FILL_PACKETS = 70;   // more than the ring can keep

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_opcode;
    logic [7:0]           i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_event_valid;
    logic [COORD_W-1:0]   o_ev_x;
    logic [COORD_W-1:0]   o_ev_y;
    logic                 o_ev_left;
    logic                 o_ev_right;
    logic                 o_ev_middle;
    logic [COORD_W-1:0]   o_cur_x;
    logic [COORD_W-1:0]   o_cur_y;
    logic [7:0]           o_cur_buttons;

    int errors;
    int pending;
    int results;
    int events;
    int drops;
    int n_items = 0;

    // shared with the receiver process
    bit idle_on  = 1'b1;
    bit stall_go = 1'b0;

    ps2_mouse_packet_cursor_fifo u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_valid (o_event_valid),
        .o_ev_x        (o_ev_x),
        .o_ev_y        (o_ev_y),
        .o_ev_left     (o_ev_left),
        .o_ev_right    (o_ev_right),
        .o_ev_middle   (o_ev_middle),
        .o_cur_x       (o_cur_x),
        .o_cur_y       (o_cur_y),
        .o_cur_buttons (o_cur_buttons)
    );

    cursor_event_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_event_valid (o_event_valid),
        .i_ev_x        (o_ev_x),
        .i_ev_y        (o_ev_y),
        .i_ev_left     (o_ev_left),
        .i_ev_right    (o_ev_right),
        .i_ev_middle   (o_ev_middle),
        .i_cur_x       (o_cur_x),
        .i_cur_y       (o_cur_y),
        .i_cur_buttons (o_cur_buttons),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_events      (events),
        .o_drops       (drops)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("tb: timeout, %0d results still pending", pending);
        $display("tb: done, errors");
        $finish;
    end

    // Receiver: random back-pressure, or a long counted hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_go) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_go = 1'b0;
            end else begin
                i_out_ready <= !idle_on || ($urandom_range(99) >= 32);
            end
        end
    end

    // Bias toward the signed extremes; dx/dy of 0x7F and 0x80 push the clamps.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted. Valid stays high afterwards,
    // so the next item can follow back to back; random gaps drop it first.
    task automatic send_item(input logic op, input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
    endtask

    task automatic send_packet(input logic [7:0] btn, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_item(OP_BYTE, btn);
        send_item(OP_BYTE, dx);
        send_item(OP_BYTE, dy);
    endtask

    // Stop offering and wait until every pop has been answered, then let the
    // clock run on idle before any register write.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Only called with the block idle (after wait_drained or reset).
    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly whole packets with random content, some followed by a pop,
    // plus lone pops and a little noise that shifts the packet alignment.
    task automatic mixed_items(input int n);
        int stop_at;
        int r;
        stop_at = n_items + n;
        while (n_items < stop_at) begin
            r = $urandom_range(99);
            if (r < 65) begin
                send_packet(pick_byte(), pick_byte(), pick_byte());
                if ($urandom_range(1)) send_item(OP_POP, 8'($urandom));
            end else if (r < 85) begin
                send_item(OP_POP, 8'($urandom));
            end else begin
                send_item(1'($urandom_range(1)), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_BYTE;
        i_data_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset screen 1920x1080 from (400, 300).
        send_item(OP_POP, 8'h00);                  // pop with empty ring
        send_packet(8'h07, 8'h7F, 8'h80);          // all buttons, +127 / -(-128)
        send_item(OP_POP, 8'hFF);                  // data byte ignored on pop
        send_packet(8'hF8, 8'h80, 8'h7F);          // only the ignored button bits
        send_item(OP_POP, 8'h00);
        send_item(OP_POP, 8'h00);                  // empty again
        wait_drained();
        // Screen shrunk below the cursor: position holds until the next packet.
        set_screen(13'd1, 13'd1);
        send_item(OP_POP, 8'h00);
        send_packet(8'h02, 8'h00, 8'h00);          // clamps to (0, 0)
        send_item(OP_POP, 8'h00);
        wait_drained();
        set_screen(13'd4096, 13'd4096);
        send_packet(8'h04, 8'h80, 8'h7F);          // low clamp on both axes
        send_item(OP_POP, 8'h00);
        wait_drained();

        // Small screen, frequent clamping at both ends.
        set_screen(13'd37, 13'd23);
        mixed_items(150);
        wait_drained();

        // Back-to-back stretch: no gaps on either side.
        idle_on = 1'b0;
        set_screen(13'd4096, 13'd1);
        mixed_items(120);
        wait_drained();
        idle_on = 1'b1;

        // Out-of-range sizes, then overfill the ring so later events drop,
        // then pop past empty.
        set_screen(13'd0, 13'd8191);
        repeat (FILL_PACKETS) send_packet(pick_byte(), pick_byte(), pick_byte());
        repeat (FIFO_DEPTH + 2) send_item(OP_POP, 8'($urandom));
        wait_drained();

        // Receiver holds off while items keep coming; the output slot fills
        // and input stalls. Then the sender pauses until all results are in.
        set_screen(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
        stall_go = 1'b1;
        send_item(OP_POP, 8'h00);
        mixed_items(40);
        wait_drained();
        mixed_items(100);
        wait_drained();

        // Back to the reset sizes.
        set_screen(13'd1920, 13'd1080);
        mixed_items(100);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d items sent, %0d pop results checked, %0d events returned, %0d dropped",
                 n_items, results, events, drops);
        $display("tb: screens 1x1, 4096x4096, 37x23, 4096x1, 0x8191, random, 1920x1080");
        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches, %0d results missing", errors, pending);
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pmc_pkg.sv
design/pmc_event_ram.sv
design/pmc_cursor.sv
design/ps2_mouse_packet_cursor_fifo.sv
test/cursor_event_checker.sv
test/tb.sv
